@@ src/spq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file imports this package.
package spq_pkg;

    // Field widths fixed by the item format
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    // Operation codes carried in the kind field
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [OCC_W-1:0]          occ_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEQ,
        ST_EMIT
    } spq_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // request channel may complete a transaction
        logic enq_direct;  // enqueue into an empty store
        logic start_scan;  // begin the insertion walk from the tail
        logic scan_shift;  // move one entry up one slot, step toward the head
        logic scan_put;    // write the new value into the open slot
        logic start_deq;   // read the head entry
        logic deq_take;    // pop the head entry
        logic flag_over;   // enqueue into a full store
        logic flag_under;  // dequeue from an empty store
        logic emit;        // load the pending result into the output register
    } spq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_valid;
        logic in_kind;
        logic full;
        logic empty;
        logic scan_stop;   // insertion slot found
        logic out_free;    // output register can take a result this cycle
    } spq_status_t;

endpackage

@@ src/spq_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: operation kind and value, valid/ready handshake.
// Depends on spq_pkg.
interface spq_req_if
    import spq_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   kind;
    value_t item_value;

    modport source (output valid, output kind, output item_value, input ready);
    modport sink   (input valid, input kind, input item_value, output ready);
endinterface

@@ src/spq_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: removed value, flags and occupancy, valid/ready handshake.
// Depends on spq_pkg.
interface spq_rsp_if
    import spq_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t removed_value;
    logic   removed_valid;
    logic   underflow;
    logic   overflow;
    occ_t   occupancy;

    modport source (
        output valid, output removed_value, output removed_valid,
        output underflow, output overflow, output occupancy, input ready
    );
    modport sink (
        input valid, input removed_value, input removed_valid,
        input underflow, input overflow, input occupancy, output ready
    );
endinterface

@@ src/sorted_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// Sorted priority queue, lowest value first, ties leave in arrival order.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl and spq_datapath.
//
// Usage:
//   req carries one operation per transaction: kind (enqueue or dequeue)
//   and item_value (signed 32 bits, used by enqueue only). rsp returns one
//   result per operation: the removed head value with removed_valid, the
//   underflow and overflow flags, and the occupancy after the operation.
//   Entries sit in a ring in one memory. An enqueue walks from the tail
//   toward the head, one stored entry per cycle, moving larger entries up
//   one slot until it finds the insertion point.
// Sequence (accept to rsp.valid, receiver ready):
//   an enqueue into a store that is neither empty nor full walks in ST_SCAN,
//   then loads the output register from ST_EMIT; a dequeue reads the head
//   entry, pops it in ST_DEQ, then goes to ST_EMIT; an enqueue into an empty
//   store, an overflow and an underflow go straight to ST_EMIT. req.ready
//   rises in the same cycle as rsp.valid. The insertion walk over the memory's
//   single read port sets the worst case (enqueue of a new lowest value into DEPTH - 1).
// Reset: the store comes up empty; entry contents are not cleared.
// Stall: a result waits in the output register while rsp.ready is low;
//   the next request is still taken and processed, and its result waits
//   until the output register drains.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    spq_cmd_t    cmd;
    spq_status_t status;

    spq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule

@@ src/spq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives the datapath through spq_cmd_t.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  spq_status_t status,
    output spq_cmd_t    cmd
);

    spq_state_t state_reg;
    spq_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    if (status.in_kind == KIND_ENQ)
                    begin
                        state_next = (status.full || status.empty) ? ST_EMIT : ST_SCAN;
                    end
                    else
                    begin
                        state_next = status.empty ? ST_EMIT : ST_DEQ;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_stop)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DEQ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = 1'b1;
                if (status.in_valid)
                begin
                    if (status.in_kind == KIND_ENQ)
                    begin
                        priority if (status.full)
                        begin
                            cmd.flag_over = 1'b1;
                        end
                        else if (status.empty)
                        begin
                            cmd.enq_direct = 1'b1;
                        end
                        else
                        begin
                            cmd.start_scan = 1'b1;
                        end
                    end
                    else
                    begin
                        if (status.empty)
                        begin
                            cmd.flag_under = 1'b1;
                        end
                        else
                        begin
                            cmd.start_deq = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_put   = status.scan_stop;
                cmd.scan_shift = !status.scan_stop;
            end
            ST_DEQ:
            begin
                cmd.deq_take = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ src/spq_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: circular sorted store in a memory, pointers, count, result
// and output registers. Depends on spq_pkg and the two channel interfaces.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    spq_req_if.sink         req,
    spq_rsp_if.source       rsp,
    input  spq_cmd_t        cmd,
    output spq_status_t     status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Step a physical index around the ring
    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

    value_t mem [DEPTH];
    value_t rdata_reg;

    ptr_t   head_reg,  head_next;
    ptr_t   tail_reg,  tail_next;
    cnt_t   count_reg, count_next;
    ptr_t   wptr_reg,  wptr_next;
    ptr_t   rptr_reg,  rptr_next;
    cnt_t   remain_reg, remain_next;
    value_t val_reg,   val_next;

    value_t res_value_reg,  res_value_next;
    logic   res_rvalid_reg, res_rvalid_next;
    logic   res_under_reg,  res_under_next;
    logic   res_over_reg,   res_over_next;

    logic   out_valid_reg,  out_valid_next;
    value_t out_value_reg,  out_value_next;
    logic   out_rvalid_reg, out_rvalid_next;
    logic   out_under_reg,  out_under_next;
    logic   out_over_reg,   out_over_next;
    occ_t   out_occ_reg,    out_occ_next;

    logic   mem_we;
    ptr_t   mem_waddr;
    ptr_t   mem_raddr;
    value_t mem_wdata;

    logic [CNT_W+OCC_W-1:0] occ_wide;

    // Memory port: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Memory addressing
    always_comb
    begin
        mem_we    = cmd.enq_direct || cmd.scan_shift || cmd.scan_put;
        mem_waddr = cmd.enq_direct ? tail_reg : wptr_reg;
        priority if (cmd.enq_direct)
        begin
            mem_wdata = req.item_value;
        end
        else if (cmd.scan_shift)
        begin
            mem_wdata = rdata_reg;
        end
        else
        begin
            mem_wdata = val_reg;
        end
        priority if (cmd.start_scan)
        begin
            mem_raddr = ptr_dec(tail_reg);
        end
        else if (cmd.scan_shift)
        begin
            mem_raddr = ptr_dec(rptr_reg);
        end
        else
        begin
            mem_raddr = head_reg;
        end
    end

    // Status toward the controller
    assign occ_wide = {{OCC_W{1'b0}}, count_reg};

    always_comb
    begin
        status.in_valid  = req.valid;
        status.in_kind   = req.kind;
        status.full      = (count_reg == CNT_W'(DEPTH));
        status.empty     = (count_reg == '0);
        status.scan_stop = (remain_reg == '0) || (rdata_reg <= val_reg);
        status.out_free  = !out_valid_reg || rsp.ready;
    end

    // Next values of pointers, count, walk state and result
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        wptr_next       = wptr_reg;
        rptr_next       = rptr_reg;
        remain_next     = remain_reg;
        val_next        = val_reg;
        res_value_next  = res_value_reg;
        res_rvalid_next = res_rvalid_reg;
        res_under_next  = res_under_reg;
        res_over_next   = res_over_reg;

        if (cmd.enq_direct || cmd.scan_put)
        begin
            tail_next       = ptr_inc(tail_reg);
            count_next      = count_reg + CNT_W'(1);
            res_value_next  = '0;
            res_rvalid_next = 1'b0;
            res_under_next  = 1'b0;
            res_over_next   = 1'b0;
        end
        if (cmd.start_scan)
        begin
            val_next    = req.item_value;
            wptr_next   = tail_reg;
            rptr_next   = ptr_dec(tail_reg);
            remain_next = count_reg;
        end
        if (cmd.scan_shift)
        begin
            wptr_next   = rptr_reg;
            rptr_next   = ptr_dec(rptr_reg);
            remain_next = remain_reg - CNT_W'(1);
        end
        if (cmd.deq_take)
        begin
            head_next       = ptr_inc(head_reg);
            count_next      = count_reg - CNT_W'(1);
            res_value_next  = rdata_reg;
            res_rvalid_next = 1'b1;
            res_under_next  = 1'b0;
            res_over_next   = 1'b0;
        end
        if (cmd.flag_over || cmd.flag_under)
        begin
            res_value_next  = '0;
            res_rvalid_next = 1'b0;
            res_under_next  = cmd.flag_under;
            res_over_next   = cmd.flag_over;
        end
    end

    // Output register: load on emit, drop once taken
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_rvalid_next = out_rvalid_reg;
        out_under_next  = out_under_reg;
        out_over_next   = out_over_reg;
        out_occ_next    = out_occ_reg;
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = res_value_reg;
            out_rvalid_next = res_rvalid_reg;
            out_under_next  = res_under_reg;
            out_over_next   = res_over_reg;
            out_occ_next    = occ_wide[OCC_W-1:0];
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        wptr_reg       <= wptr_next;
        rptr_reg       <= rptr_next;
        remain_reg     <= remain_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_rvalid_reg <= res_rvalid_next;
        res_under_reg  <= res_under_next;
        res_over_reg   <= res_over_next;
        out_value_reg  <= out_value_next;
        out_rvalid_reg <= out_rvalid_next;
        out_under_reg  <= out_under_next;
        out_over_reg   <= out_over_next;
        out_occ_reg    <= out_occ_next;
    end

    // Drive the channels
    assign req.ready         = cmd.accept;
    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_value = out_value_reg;
    assign rsp.removed_valid = out_rvalid_reg;
    assign rsp.underflow     = out_under_reg;
    assign rsp.overflow      = out_over_reg;
    assign rsp.occupancy     = out_occ_reg;

endmodule

@@ src/spq_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for sorted_priority_queue_unit, attached by bind.
// Depends on spq_pkg and the top level's channel interfaces.
module spq_checker
    import spq_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   req_valid,
    input logic   req_ready,
    input logic   rsp_valid,
    input logic   rsp_ready,
    input value_t removed_value,
    input logic   removed_valid,
    input logic   underflow,
    input logic   overflow,
    input occ_t   occupancy
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp dropped before it was taken");

    // One operation in flight: busy right after a request transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous operation in flight");

    // Outcomes exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(removed_valid && (underflow || overflow))
                      && !(underflow && overflow))
        else $error("conflicting result flags");

    // No removed value without a dequeued entry
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !removed_valid |-> removed_value == '0)
        else $error("removed_value nonzero without removed_valid");

    // Underflow only from an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && underflow |-> occupancy == '0)
        else $error("underflow with nonzero occupancy");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .removed_value (rsp.removed_value),
    .removed_valid (rsp.removed_valid),
    .underflow     (rsp.underflow),
    .overflow      (rsp.overflow),
    .occupancy     (rsp.occupancy)
);
